// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared definitions for the button press classifier
// Register indexes, reset values, event codes and the flag bundle that the
// tick logic and the top level exchange.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUZZER     = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] BUZZER_RESET     = 16'd200;

    typedef logic [1:0] press_event_t;
    localparam press_event_t EV_NONE  = 2'd0;
    localparam press_event_t EV_SHORT = 2'd1;
    localparam press_event_t EV_LONG  = 2'd2;

    typedef struct packed {
        logic last_level;
        logic pressed;
        logic led_state;
        logic buzzing;
    } bpc_flags_t;

    localparam bpc_flags_t FLAGS_RESET = '{
        last_level: 1'b1,
        pressed:    1'b0,
        led_state:  1'b0,
        buzzing:    1'b0
    };

endpackage

// ===== design/button_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier_core: debounced short/long button press detector
// One tick per input transfer; one result transfer per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the raw active-low
// button level. The block takes one tick per clock cycle: the tick logic
// sits between the state registers and a single result register, and a new
// tick is accepted whenever that register is empty or being drained in the
// same cycle, so throughput is one item per cycle with a registered result.
// A stalled output holds the input off only while the result register is
// full. Registers (debounce, long-press, buzzer lengths) are written through
// the cfg port, by the user only while the block is idle; the block does not enforce this.
module button_press_classifier_core #(
    parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] button_level
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [0] led_on, [1] buzzer_on,
                                                               // [3:2] press_event
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
    import bpc_pkg::*;

    logic [CFG_WIDTH-1:0]   debounce_reg;
    logic [CFG_WIDTH-1:0]   long_press_reg;
    logic [CFG_WIDTH-1:0]   buzzer_reg;

    bpc_flags_t             flags_reg;
    bpc_flags_t             flags_next;
    logic [COUNT_WIDTH-1:0] since_reg;
    logic [COUNT_WIDTH-1:0] since_next;
    logic [COUNT_WIDTH-1:0] press_len_reg;
    logic [COUNT_WIDTH-1:0] press_len_next;
    logic [COUNT_WIDTH-1:0] buzz_len_reg;
    logic [COUNT_WIDTH-1:0] buzz_len_next;
    press_event_t           event_next;

    logic                   out_valid_reg;
    logic                   out_led_reg;
    logic                   out_buzz_reg;
    press_event_t           out_event_reg;
    logic                   in_fire;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            buzzer_reg     <= BUZZER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                REG_BUZZER:     buzzer_reg     <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    bpc_tick_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick (
        .button_level      (s_axis_tdata[0]),
        .flags             (flags_reg),
        .since_change      (since_reg),
        .press_length      (press_len_reg),
        .buzz_length       (buzz_len_reg),
        .debounce_ticks    (debounce_reg),
        .long_press_ticks  (long_press_reg),
        .buzzer_ticks      (buzzer_reg),
        .flags_next        (flags_next),
        .since_change_next (since_next),
        .press_length_next (press_len_next),
        .buzz_length_next  (buzz_len_next),
        .press_event       (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= FLAGS_RESET;
            since_reg     <= '0;
            press_len_reg <= '0;
            buzz_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                flags_reg     <= flags_next;
                since_reg     <= since_next;
                press_len_reg <= press_len_next;
                buzz_len_reg  <= buzz_len_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_led_reg   <= flags_next.led_state;
            out_buzz_reg  <= flags_next.buzzing;
            out_event_reg <= event_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_event_reg, out_buzz_reg, out_led_reg};

    // a short press must flip the LED
    a_short_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && event_next == EV_SHORT) |-> (flags_next.led_state != flags_reg.led_state))
        else $error("short press did not toggle LED");

    // a press only starts on a low level
    a_press_on_low: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !flags_reg.pressed && flags_next.pressed) |-> !s_axis_tdata[0])
        else $error("press started on released level");

    // an event is only reported when a press ends
    a_event_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && event_next != EV_NONE) |-> (flags_reg.pressed && !flags_next.pressed))
        else $error("event without release");

    // an empty result register never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

// ===== design/bpc_tick_logic.sv =====
// ----------------------------------------------------------------------------
// bpc_tick_logic: next-state logic for one tick
// Saturating counters, debounce decision, press classification and buzzer
// pulse timing, all combinational.
// ----------------------------------------------------------------------------
module bpc_tick_logic #(
    parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           button_level,
    input  bpc_pkg::bpc_flags_t            flags,
    input  logic [COUNT_WIDTH-1:0]         since_change,
    input  logic [COUNT_WIDTH-1:0]         press_length,
    input  logic [COUNT_WIDTH-1:0]         buzz_length,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]  debounce_ticks,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]  long_press_ticks,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]  buzzer_ticks,
    output bpc_pkg::bpc_flags_t            flags_next,
    output logic [COUNT_WIDTH-1:0]         since_change_next,
    output logic [COUNT_WIDTH-1:0]         press_length_next,
    output logic [COUNT_WIDTH-1:0]         buzz_length_next,
    output bpc_pkg::press_event_t          press_event
);
    import bpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic [COUNT_WIDTH-1:0] since_inc;
    logic [COUNT_WIDTH-1:0] press_inc;
    logic [COUNT_WIDTH-1:0] buzz_inc;
    logic                   stable;

    always_comb
    begin
        since_inc = (button_level != flags.last_level) ? '0 : sat_inc(since_change);
        press_inc = flags.pressed ? sat_inc(press_length) : press_length;
        buzz_inc  = flags.buzzing ? sat_inc(buzz_length) : buzz_length;
        stable    = CMP_W'(since_inc) > CMP_W'(debounce_ticks);

        flags_next            = flags;
        flags_next.last_level = button_level;
        since_change_next     = since_inc;
        press_length_next     = press_inc;
        buzz_length_next      = buzz_inc;
        press_event           = EV_NONE;

        if (stable)
        begin
            if (!flags.pressed && !button_level)
            begin
                flags_next.pressed = 1'b1;
                press_length_next  = '0;
            end
            else if (flags.pressed && button_level)
            begin
                flags_next.pressed = 1'b0;
                if (CMP_W'(press_inc) >= CMP_W'(long_press_ticks))
                begin
                    flags_next.buzzing = 1'b1;
                    buzz_length_next   = '0;
                    press_event        = EV_LONG;
                end
                else
                begin
                    flags_next.led_state = !flags.led_state;
                    press_event          = EV_SHORT;
                end
            end
        end

        // pulse end is checked after a possible restart, so a zero length never sounds
        if (flags_next.buzzing && (CMP_W'(buzz_length_next) >= CMP_W'(buzzer_ticks)))
        begin
            flags_next.buzzing = 1'b0;
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for button_press_classifier_core
// Ticks are pushed through the input stream as runs of one button level. A
// behavioural model of the debounce and press-length logic predicts each
// result transfer, and the sink side checks it field by field. A short
// directed plan comes first, then randomised press sequences under shifting
// thresholds, and finally a stretch with no idling at extreme and small
// thresholds.
// ----------------------------------------------------------------------------
module tb;

    import bpc_pkg::*;

    localparam int                            CW           = COUNT_WIDTH_DEF;
    localparam logic [CFG_INDEX_WIDTH-1:0]    REG_UNUSED   = 2'd3;
    localparam int unsigned                   RANDOM_TICKS = 440;
    localparam int unsigned                   SINK_HOLD    = 300;
    localparam int unsigned                   CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned                   PLAN_LEN     = 23;

    typedef struct packed {
        logic         led_on;
        logic         buzzer_on;
        press_event_t press_event;
    } tick_result_t;

    typedef enum logic {ROW_TICKS, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_WIDTH-1:0]       value;   // level in bit 0 for tick rows
        int unsigned                reps;
        bit                         pinned;  // last tick checked against want
        tick_result_t               want;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata = 8'd0;   // [0] button_level
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [7:0]                 m_axis_tdata;          // [0] led_on, [1] buzzer_on,
                                                       // [3:2] press_event
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_wdata = '0;

    // model state
    logic                 level_seen;
    logic [CW-1:0]        stable_ticks;
    logic                 held;
    logic [CW-1:0]        hold_ticks;
    logic                 led_lit;
    logic                 buzz_active;
    logic [CW-1:0]        buzz_run;
    logic [CFG_WIDTH-1:0] debounce_cfg;
    logic [CFG_WIDTH-1:0] long_cfg;
    logic [CFG_WIDTH-1:0] buzz_cfg;

    tick_result_t tick_results_q[$];
    bit           idle_en = 1'b1;
    bit           hold_results_req = 1'b0;
    int unsigned  fail_count = 0;
    int unsigned  ticks_sent = 0;
    int unsigned  short_presses = 0;
    int unsigned  long_presses = 0;
    int unsigned  reg_writes = 0;
    int unsigned  settings_used = 0;
    int unsigned  cycle_count = 0;

    plan_row_t plan_rows [0:PLAN_LEN-1] = '{
        '{ROW_TICKS, REG_UNUSED,     16'd1,     1, 1'b1, {1'b0, 1'b0, EV_NONE}},
        '{ROW_WRITE, REG_DEBOUNCE,   16'd0,     0, 1'b0, '0},
        '{ROW_WRITE, REG_LONG_PRESS, 16'd3,     0, 1'b0, '0},
        '{ROW_WRITE, REG_BUZZER,     16'd2,     0, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     2, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b0, EV_SHORT}},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     5, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b1, EV_LONG}},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b0, EV_NONE}},
        '{ROW_WRITE, REG_BUZZER,     16'd0,     0, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     5, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b0, EV_LONG}},
        '{ROW_WRITE, REG_LONG_PRESS, 16'd0,     0, 1'b0, '0},
        '{ROW_WRITE, REG_BUZZER,     16'd20,    0, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     2, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b1, EV_LONG}},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     2, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b1, EV_LONG}},
        '{ROW_WRITE, REG_UNUSED,     16'hFFFF,  0, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     1, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     1, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd0,     2, 1'b0, '0},
        '{ROW_TICKS, REG_UNUSED,     16'd1,     2, 1'b1, {1'b1, 1'b1, EV_LONG}}
    };

    button_press_classifier_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [CW-1:0] count_up(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // One millisecond tick of the debounce and press-length logic
    function automatic tick_result_t classify_tick(input logic lvl);
        tick_result_t r;
        r.press_event = EV_NONE;
        if (lvl != level_seen)
        begin
            level_seen   = lvl;
            stable_ticks = '0;
        end
        else
        begin
            stable_ticks = count_up(stable_ticks);
        end
        if (held)
            hold_ticks = count_up(hold_ticks);
        if (buzz_active)
            buzz_run = count_up(buzz_run);
        if (stable_ticks > debounce_cfg)
        begin
            if (!held && lvl == 1'b0)
            begin
                held       = 1'b1;
                hold_ticks = '0;
            end
            else if (held && lvl == 1'b1)
            begin
                held = 1'b0;
                if (hold_ticks >= long_cfg)
                begin
                    buzz_active   = 1'b1;
                    buzz_run      = '0;
                    r.press_event = EV_LONG;
                    long_presses++;
                end
                else
                begin
                    led_lit       = ~led_lit;
                    r.press_event = EV_SHORT;
                    short_presses++;
                end
            end
        end
        // a zero-length pulse ends in the tick it starts
        if (buzz_active && buzz_run >= buzz_cfg)
            buzz_active = 1'b0;
        r.led_on    = led_lit;
        r.buzzer_on = buzz_active;
        return r;
    endfunction

    task automatic send_tick(input logic lvl, input bit pinned = 1'b0,
                             input tick_result_t pinned_res = '0);
        tick_result_t r;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        r = classify_tick(lvl);
        tick_results_q.push_back(pinned ? pinned_res : r);
        ticks_sent++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, lvl};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic hold_level(input logic lvl, input int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // stop offering and wait for every pending result transfer
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE:   debounce_cfg = val;
            REG_LONG_PRESS: long_cfg     = val;
            REG_BUZZER:     buzz_cfg     = val;
            default:        ;
        endcase
        reg_writes++;
    endtask

    task automatic set_regs(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] lng,
                            input logic [CFG_WIDTH-1:0] buz);
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_BUZZER, buz);
        settings_used++;
    endtask

    // contact chatter either side of a clean hold
    task automatic press_and_release(input int unsigned low_len, input int unsigned high_len);
        repeat ($urandom_range(0, 3)) hold_level(1'($urandom_range(0, 1)), $urandom_range(1, 2));
        hold_level(1'b0, low_len);
        repeat ($urandom_range(0, 3)) hold_level(1'($urandom_range(0, 1)), $urandom_range(1, 2));
        hold_level(1'b1, high_len);
    endtask

    // result sink with random back-pressure and one long hold on request
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_results_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                hold_results_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tick_results_q.size() == 0)
            begin
                $error("result transfer with no tick pending: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = tick_results_q.pop_front();
                if (m_axis_tdata[0] !== want.led_on)
                begin
                    $error("led_on: expected %0d, got %0d", want.led_on, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[1] !== want.buzzer_on)
                begin
                    $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, m_axis_tdata[1]);
                    fail_count++;
                end
                if (m_axis_tdata[3:2] !== want.press_event)
                begin
                    $error("press_event: expected %0d, got %0d", want.press_event,
                           m_axis_tdata[3:2]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned deb;
        int unsigned lng;
        int unsigned buz;
        int unsigned phase;
        int unsigned start_ticks;

        level_seen   = FLAGS_RESET.last_level;
        stable_ticks = '0;
        held         = FLAGS_RESET.pressed;
        hold_ticks   = '0;
        led_lit      = FLAGS_RESET.led_state;
        buzz_active  = FLAGS_RESET.buzzing;
        buzz_run     = '0;
        debounce_cfg = DEBOUNCE_RESET;
        long_cfg     = LONG_PRESS_RESET;
        buzz_cfg     = BUZZER_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (plan_rows[i])
        begin
            if (plan_rows[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(plan_rows[i].reg_idx, plan_rows[i].value);
            end
            else
            begin
                for (int j = 0; j < plan_rows[i].reps; j++)
                    send_tick(plan_rows[i].value[0],
                              plan_rows[i].pinned && j == plan_rows[i].reps - 1,
                              plan_rows[i].want);
            end
        end

        // reset thresholds: one short press
        set_regs(DEBOUNCE_RESET, LONG_PRESS_RESET, BUZZER_RESET);
        press_and_release(40, 40);

        // random presses under small thresholds
        phase       = 0;
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < RANDOM_TICKS)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            deb = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            lng = $urandom_range(0, 30);
            buz = $urandom_range(0, 15);
            set_regs(16'(deb), 16'(lng), 16'(buz));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 16'($urandom));
            // first round only: output held off while the sender keeps offering
            if (phase == 0)
                hold_results_req = 1'b1;
            repeat ($urandom_range(3, 6))
            begin
                if ($urandom_range(0, 4) == 0)
                    hold_level(1'($urandom_range(0, 1)), $urandom_range(1, deb + 1));
                press_and_release(deb + 1 + $urandom_range(0, lng + 4),
                                  deb + 1 + $urandom_range(0, buz + 4));
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
            phase++;
        end

        // closing stretch with no idling: extreme thresholds, then steady presses
        idle_en = 1'b0;
        set_regs(16'hFFFF, 16'd0, 16'd0);
        hold_level(1'b0, 20);
        hold_level(1'b1, 3);
        set_regs(16'd0, 16'hFFFF, 16'hFFFF);
        press_and_release(6, 4);
        set_regs(16'd1, 16'd6, 16'd3);
        repeat (4)
            press_and_release(2 + $urandom_range(0, 10), 2 + $urandom_range(0, 6));

        drain();
        $display("Ran %0d ticks over %0d threshold settings (%0d register writes)",
                 ticks_sent, settings_used, reg_writes);
        $display("Saw %0d short and %0d long presses, incl. extreme thresholds and stalls",
                 short_presses, long_presses);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
